// ----- rtl/core/atrlm_pkg.sv -----
// ----------------------------------------------------------------------------
// atrlm_pkg: shared definitions of the AT response line matcher
// Action and outcome codes, register indexes, field widths and character
// constants used by the channel interfaces and the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package atrlm_pkg;

  // line buffer capacity in bytes, one slot kept spare as in a C string
  localparam int LINE_CAPACITY = 128;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int BYTE_W    = 8;
  localparam int OUTCOME_W = 2;
  localparam int LEN_W     = 7;
  localparam int PATTERN_W = 64;
  localparam int PLEN_W    = 4;
  localparam int TICKS_W   = 16;
  localparam int LFWAIT_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = PATTERN_W;

  // longest line that is stored, bounded by the buffer and by the length field
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int STORE_LIMIT = (LINE_CAPACITY - 1 < LEN_MAX) ? LINE_CAPACITY - 1 : LEN_MAX;

  // register reset values
  localparam logic [PLEN_W-1:0]   PLEN_RESET    = PLEN_W'(1);
  localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = TICKS_W'(6000);
  localparam logic [LFWAIT_W-1:0] LFWAIT_RESET  = LFWAIT_W'(50);
  localparam logic [PLEN_W-1:0]   PLEN_MAX      = PLEN_W'(8);

  // characters
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_SUCCESS = 2'd0,
    OUT_ERROR   = 2'd1,
    OUT_TIMEOUT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE     = 3'd0,
    REG_MATCH_PATTERN  = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_TIMEOUT_MS     = 3'd3,
    REG_LF_WAIT_TICKS  = 3'd4
  } cfg_reg_t;

  // decision on a finished line
  typedef struct packed {
    logic     hit;
    outcome_t code;
  } line_dec_t;

  // characters of "OK"
  function automatic logic [BYTE_W-1:0] ok_char(input logic idx);
    return idx ? 8'h4B : 8'h4F;
  endfunction

  // characters of "ERROR"
  function automatic logic [BYTE_W-1:0] error_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/atrlm_in_if.sv -----
// ----------------------------------------------------------------------------
// atrlm_in_if: input item channel
// Valid/ready channel carrying one action and one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlm_in_if
  import atrlm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/atrlm_out_if.sv -----
// ----------------------------------------------------------------------------
// atrlm_out_if: result item channel
// Valid/ready channel carrying the outcome and the deciding line length.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrlm_out_if
  import atrlm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [LEN_W-1:0]     line_length;

  modport source (output valid, output outcome, output line_length, input ready);
  modport sink   (input valid, input outcome, input line_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/at_response_line_matcher.sv -----
// ----------------------------------------------------------------------------
// at_response_line_matcher: modem reply line matcher
// Assembles received bytes into lines and decides on OK, ERROR, a prefix
// pattern or an overall tick deadline.
// ----------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  in_ch     in    valid / ready     action, data_byte
//  out_ch    out   valid / ready     outcome, line_length
//  cfg       in    cfg_we            cfg_index, cfg_wdata
//
//  one item per cycle: an item is captured in the input register, then the
//  line logic updates the state and loads the result register as the stage advances
//  the input register holds while a result waits unaccepted in the result register
//  synchronous active-low reset restores register defaults and goes idle
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_line_matcher
  import atrlm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  atrlm_in_if.sink                   in_ch,
  atrlm_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic                 match_mode_r;
  logic [PATTERN_W-1:0] match_pattern_r;
  logic [PLEN_W-1:0]    pattern_length_r;
  logic [TICKS_W-1:0]   timeout_ms_r;
  logic [LFWAIT_W-1:0]  lf_wait_ticks_r;

  // input register
  logic                in_valid_r;
  logic [ACTION_W-1:0] action_r;
  logic [BYTE_W-1:0]   byte_r;

  // line state
  logic                waiting_r,  waiting_nxt;
  logic                cr_r,       cr_nxt;
  logic [LFWAIT_W-1:0] lf_left_r,  lf_left_nxt;
  logic [TICKS_W-1:0]  ticks_r,    ticks_nxt;
  logic [LEN_W-1:0]    len_r,      len_nxt;
  logic                ok_r,       ok_nxt;
  logic                err_r,      err_nxt;
  logic                pre_r,      pre_nxt;

  // result register
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] outcome_r;
  logic [LEN_W-1:0]     out_len_r;

  logic                 res_v;
  outcome_t             res_code;
  logic [LEN_W-1:0]     res_len;
  logic                 advance;
  logic [PLEN_W-1:0]    plen;

  // effective pattern length, values above eight act as eight
  assign plen = (pattern_length_r > PLEN_MAX) ? PLEN_MAX : pattern_length_r;

  // the input stage moves on unless its result would overwrite a waiting one
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = outcome_r;
  assign out_ch.line_length = out_len_r;

  // decision on a line that ends with the given length and match flags
  function automatic line_dec_t decide(input logic [LEN_W-1:0] len, input logic okf,
                                       input logic errf, input logic pref);
    line_dec_t d;
    d.hit  = 1'b0;
    d.code = OUT_SUCCESS;
    if (len != '0) begin
      if (match_mode_r) begin
        if (pref && (len >= LEN_W'(plen))) d.hit = 1'b1;
      end else if (okf && (len == LEN_W'(2))) begin
        d.hit = 1'b1;
      end else if (errf && (len == LEN_W'(5))) begin
        d.hit  = 1'b1;
        d.code = OUT_ERROR;
      end
    end
    return d;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r     <= 1'b0;
      match_pattern_r  <= '0;
      pattern_length_r <= PLEN_RESET;
      timeout_ms_r     <= TIMEOUT_RESET;
      lf_wait_ticks_r  <= LFWAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_MODE:     match_mode_r     <= cfg_wdata[0];
        REG_MATCH_PATTERN:  match_pattern_r  <= cfg_wdata;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[PLEN_W-1:0];
        REG_TIMEOUT_MS:     timeout_ms_r     <= cfg_wdata[TICKS_W-1:0];
        REG_LF_WAIT_TICKS:  lf_wait_ticks_r  <= cfg_wdata[LFWAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      action_r <= in_ch.action;
      byte_r   <= in_ch.data_byte;
    end
  end

  // line logic for one item
  always_comb begin
    line_dec_t d;
    logic      done;
    logic [BYTE_W-1:0] pchar;
    d           = '0;
    done        = 1'b0;
    pchar       = '0;
    waiting_nxt = waiting_r;
    cr_nxt      = cr_r;
    lf_left_nxt = lf_left_r;
    ticks_nxt   = ticks_r;
    len_nxt     = len_r;
    ok_nxt      = ok_r;
    err_nxt     = err_r;
    pre_nxt     = pre_r;
    res_v       = 1'b0;
    res_code    = OUT_SUCCESS;
    res_len     = '0;

    if (action_r == ACT_START) begin
      // start or restart a wait with an empty line
      waiting_nxt = 1'b1;
      ticks_nxt   = timeout_ms_r;
      cr_nxt = 1'b0; lf_left_nxt = '0; len_nxt = '0;
      ok_nxt = 1'b1; err_nxt = 1'b1; pre_nxt = 1'b1;
    end else if (waiting_r && action_r == ACT_TICK) begin
      if (ticks_r <= TICKS_W'(1)) begin
        // deadline reached
        ticks_nxt   = '0;
        waiting_nxt = 1'b0;
        cr_nxt = 1'b0; lf_left_nxt = '0; len_nxt = '0;
        ok_nxt = 1'b1; err_nxt = 1'b1; pre_nxt = 1'b1;
        res_v    = 1'b1;
        res_code = OUT_TIMEOUT;
      end else begin
        ticks_nxt = ticks_r - TICKS_W'(1);
        if (cr_r) begin
          if (lf_left_r <= LFWAIT_W'(1)) begin
            // no LF came after CR: the line ends here
            d = decide(len_r, ok_r, err_r, pre_r);
            res_v = d.hit; res_code = d.code; res_len = len_r;
            if (d.hit) waiting_nxt = 1'b0;
            cr_nxt = 1'b0; lf_left_nxt = '0; len_nxt = '0;
            ok_nxt = 1'b1; err_nxt = 1'b1; pre_nxt = 1'b1;
          end else begin
            lf_left_nxt = lf_left_r - LFWAIT_W'(1);
          end
        end
      end
    end else if (waiting_r && action_r == ACT_BYTE) begin
      // a pending CR ends the line on any byte
      if (cr_r) begin
        d = decide(len_r, ok_r, err_r, pre_r);
        res_v = d.hit; res_code = d.code; res_len = len_r;
        if (d.hit) waiting_nxt = 1'b0;
        cr_nxt = 1'b0; lf_left_nxt = '0; len_nxt = '0;
        ok_nxt = 1'b1; err_nxt = 1'b1; pre_nxt = 1'b1;
        done = d.hit || (byte_r == CH_LF);
      end
      if (!done) begin
        if (byte_r == CH_CR) begin
          cr_nxt      = 1'b1;
          lf_left_nxt = lf_wait_ticks_r;
        end else if (byte_r == CH_LF) begin
          // LF ends the line
          d = decide(len_nxt, ok_nxt, err_nxt, pre_nxt);
          res_v = d.hit; res_code = d.code; res_len = len_nxt;
          if (d.hit) waiting_nxt = 1'b0;
          cr_nxt = 1'b0; lf_left_nxt = '0; len_nxt = '0;
          ok_nxt = 1'b1; err_nxt = 1'b1; pre_nxt = 1'b1;
        end else if (len_nxt < LEN_W'(STORE_LIMIT)) begin
          // store the byte and update the match flags
          pchar = match_pattern_r[{len_nxt[2:0], 3'b000} +: BYTE_W];
          if (len_nxt < LEN_W'(2) && byte_r != ok_char(len_nxt[0])) ok_nxt = 1'b0;
          if (len_nxt < LEN_W'(5) && byte_r != error_char(len_nxt[2:0])) err_nxt = 1'b0;
          if (len_nxt < LEN_W'(plen) && byte_r != pchar) pre_nxt = 1'b0;
          len_nxt = len_nxt + LEN_W'(1);
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      cr_r      <= 1'b0;
      lf_left_r <= '0;
      ticks_r   <= '0;
      len_r     <= '0;
      ok_r      <= 1'b1;
      err_r     <= 1'b1;
      pre_r     <= 1'b1;
    end else if (advance) begin
      waiting_r <= waiting_nxt;
      cr_r      <= cr_nxt;
      lf_left_r <= lf_left_nxt;
      ticks_r   <= ticks_nxt;
      len_r     <= len_nxt;
      ok_r      <= ok_nxt;
      err_r     <= err_nxt;
      pre_r     <= pre_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (advance && res_v)            out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_v) begin
      outcome_r <= res_code;
      out_len_r <= res_len;
    end
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the AT response line matcher
// Drives start, byte and tick items with random gaps and random result stalls,
// predicts each reply from a behavioral copy of the line matcher or a directed row, checks
// each result item field by field, in order, across several register settings.
// ----------------------------------------------------------------------------

module testbench;
  import atrlm_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_LIMIT   = 2000;

  localparam logic [15:0] TXT_OK    = "OK";
  localparam logic [39:0] TXT_ERROR = "ERROR";

  typedef struct packed {
    outcome_t         outcome;
    logic [LEN_W-1:0] len;
  } reply_t;

  // one row of the directed part: an item or a register write
  typedef struct {
    bit                    is_cfg;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    action_t               act;
    logic [BYTE_W-1:0]     ch;
    bit                    typed;
    bit                    hit;
    reply_t                reply;
  } step_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  atrlm_in_if  in_ch ();
  atrlm_out_if out_ch ();

  at_response_line_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies
  logic                  mode_cfg    = 1'b0;
  logic [PATTERN_W-1:0]  pattern_cfg = '0;
  logic [PLEN_W-1:0]     plen_cfg    = PLEN_RESET;
  logic [TICKS_W-1:0]    timeout_cfg = TIMEOUT_RESET;
  logic [LFWAIT_W-1:0]   lfwait_cfg  = LFWAIT_RESET;

  // matcher state copy
  bit                    awaiting_reply = 1'b0;
  bit                    cr_seen        = 1'b0;
  logic [LFWAIT_W-1:0]   lf_left        = '0;
  logic [TICKS_W-1:0]    budget_left    = '0;
  logic [LEN_W-1:0]      line_len       = '0;
  bit                    ok_match       = 1'b1;
  bit                    err_match      = 1'b1;
  bit                    pfx_match      = 1'b1;

  reply_t expected_replies[$];
  step_t  directed_steps[$];
  int     fail_count  = 0;
  int     live_items  = 0;
  int     ready_hold  = 0;
  int     idle_cycles = 0;
  bit     calm        = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length, mostly short with a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_char();
    if ($urandom_range(0, 3) != 0) return BYTE_W'($urandom_range(8'h20, 8'h7E));
    return BYTE_W'($urandom);
  endfunction

  function automatic int eff_plen();
    return (plen_cfg > PLEN_MAX) ? int'(PLEN_MAX) : int'(plen_cfg);
  endfunction

  function automatic void clear_line();
    cr_seen   = 1'b0;
    lf_left   = '0;
    line_len  = '0;
    ok_match  = 1'b1;
    err_match = 1'b1;
    pfx_match = 1'b1;
  endfunction

  // finish the assembled line, report a reply if it decides the wait
  function automatic bit close_line(output reply_t r);
    logic [LEN_W-1:0] len;
    bit               hit;
    outcome_t         oc;
    len = line_len;
    hit = 1'b0;
    oc  = OUT_SUCCESS;
    if (len != 0) begin
      if (mode_cfg) begin
        if (pfx_match && len >= eff_plen()) hit = 1'b1;
      end else if (ok_match && len == 2) begin
        hit = 1'b1;
      end else if (err_match && len == 5) begin
        hit = 1'b1;
        oc  = OUT_ERROR;
      end
    end
    clear_line();
    r.outcome = oc;
    r.len     = len;
    if (hit) awaiting_reply = 1'b0;
    return hit;
  endfunction

  // advance the matcher copy by one item, 1 when a reply is due
  function automatic bit predict_reply(input action_t act, input logic [BYTE_W-1:0] ch,
                                       output reply_t r);
    int idx;
    r = '0;
    if (act == ACT_START) begin
      awaiting_reply = 1'b1;
      budget_left    = timeout_cfg;
      clear_line();
      return 1'b0;
    end
    if (!awaiting_reply) return 1'b0;

    // overall deadline first, then the optional LF wait
    if (act == ACT_TICK) begin
      if (budget_left <= 1) begin
        budget_left    = '0;
        awaiting_reply = 1'b0;
        clear_line();
        r.outcome = OUT_TIMEOUT;
        r.len     = '0;
        return 1'b1;
      end
      budget_left--;
      if (cr_seen) begin
        if (lf_left <= 1) return close_line(r);
        lf_left--;
      end
      return 1'b0;
    end
    if (act != ACT_BYTE) return 1'b0;

    // a byte after CR ends the line; a deciding line swallows the byte
    if (cr_seen) begin
      if (ch == CH_LF) return close_line(r);
      if (close_line(r)) return 1'b1;
    end
    if (ch == CH_CR) begin
      cr_seen = 1'b1;
      lf_left = lfwait_cfg;
      return 1'b0;
    end
    if (ch == CH_LF) return close_line(r);

    // store the byte and track the three comparisons
    idx = line_len;
    if (idx < STORE_LIMIT) begin
      if (idx < 2 && ch != TXT_OK[8*(1-idx) +: 8]) ok_match = 1'b0;
      if (idx < 5 && ch != TXT_ERROR[8*(4-idx) +: 8]) err_match = 1'b0;
      if (idx < eff_plen() && ch != pattern_cfg[8*idx +: 8]) pfx_match = 1'b0;
      line_len = LEN_W'(idx + 1);
    end
    return 1'b0;
  endfunction

  function automatic step_t step_item(input action_t a, input logic [BYTE_W-1:0] c,
                                      input bit typed = 1'b0, input bit hit = 1'b0,
                                      input outcome_t oc = OUT_SUCCESS,
                                      input logic [LEN_W-1:0] len = '0);
    step_t s;
    s.is_cfg        = 1'b0;
    s.reg_idx       = REG_MATCH_MODE;
    s.reg_val       = '0;
    s.act           = a;
    s.ch            = c;
    s.typed         = typed;
    s.hit           = hit;
    s.reply.outcome = oc;
    s.reply.len     = len;
    return s;
  endfunction

  function automatic step_t step_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s         = step_item(ACT_NONE, '0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // hand one item to the matcher and record what it should answer
  task automatic send_item(input action_t act, input logic [BYTE_W-1:0] ch,
                           input bit typed = 1'b0, input bit hit = 1'b0,
                           input reply_t typed_r = '0);
    int     gap;
    reply_t r;
    bit     got;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= ch;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    live_items++;
    got = predict_reply(act, ch, r);
    if (typed) begin
      got = hit;
      r   = typed_r;
    end
    if (got) expected_replies.push_back(r);
  endtask

  // stop sending and let every outstanding result come out
  task automatic wait_for_quiet();
    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MATCH_MODE:     mode_cfg    = val[0];
      REG_MATCH_PATTERN:  pattern_cfg = val;
      REG_PATTERN_LENGTH: plen_cfg    = val[PLEN_W-1:0];
      REG_TIMEOUT_MS:     timeout_cfg = val[TICKS_W-1:0];
      REG_LF_WAIT_TICKS:  lfwait_cfg  = val[LFWAIT_W-1:0];
      default: ;
    endcase
  endtask

  // one modem reply: start, a few lines with random endings, stray ticks
  task automatic send_reply_sequence();
    logic [BYTE_W-1:0] line_q[$];
    int nlines;
    int kind;
    int span;
    int r;
    int k;
    if ($urandom_range(0, 19) == 0) send_item(ACT_NONE, BYTE_W'($urandom));
    if ($urandom_range(0, 9) != 0) send_item(ACT_START, BYTE_W'($urandom));

    // silent modem, ticks only
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 50)) send_item(ACT_TICK, BYTE_W'($urandom));
      return;
    end

    nlines = $urandom_range(1, 4);
    repeat (nlines) begin
      line_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        for (k = 0; k < 2; k++) line_q.push_back(TXT_OK[8*(1-k) +: 8]);
      end else if (kind < 40) begin
        for (k = 0; k < 5; k++) line_q.push_back(TXT_ERROR[8*(4-k) +: 8]);
      end else if (kind < 60 || kind >= 98) begin
        // pattern prefix with a tail, rarely past the line capacity
        for (k = 0; k < eff_plen(); k++) line_q.push_back(pattern_cfg[8*k +: 8]);
        span = (kind >= 98) ? $urandom_range(120, 140) : line_q.size() + $urandom_range(0, 6);
        while (line_q.size() < span) line_q.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 72) begin
        // near misses of OK and ERROR
        if (kind < 66) begin
          span = $urandom_range(1, 2);
          for (k = 0; k < span; k++) line_q.push_back(TXT_OK[8*(1-k) +: 8]);
        end else begin
          span = $urandom_range(1, 5);
          for (k = 0; k < span; k++) line_q.push_back(TXT_ERROR[8*(4-k) +: 8]);
        end
        if ($urandom_range(0, 1) != 0) line_q.push_back(rand_char());
      end else if (kind >= 80) begin
        span = $urandom_range(1, 12);
        repeat (span) line_q.push_back(rand_char());
      end

      for (k = 0; k < line_q.size(); k++) begin
        if ($urandom_range(0, 11) == 0) send_item(ACT_TICK, BYTE_W'($urandom));
        send_item(ACT_BYTE, line_q[k]);
      end

      // line ending
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_item(ACT_BYTE, CH_LF);
      end else if (r < 60) begin
        send_item(ACT_BYTE, CH_CR);
        send_item(ACT_BYTE, CH_LF);
      end else if (r < 80) begin
        send_item(ACT_BYTE, CH_CR);
      end else begin
        send_item(ACT_BYTE, CH_CR);
        repeat ($urandom_range(0, (lfwait_cfg > 19) ? 20 : lfwait_cfg + 1))
          send_item(ACT_TICK, BYTE_W'($urandom));
      end
    end
    repeat ($urandom_range(0, 5)) send_item(ACT_TICK, BYTE_W'($urandom));
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin : result_check
    reply_t head;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result item: outcome %0d line_length %0d",
               out_ch.outcome, out_ch.line_length);
        fail_count++;
      end else begin
        head = expected_replies.pop_front();
        if (out_ch.outcome !== head.outcome) begin
          $error("outcome: expected %0d, actual %0d", head.outcome, out_ch.outcome);
          fail_count++;
        end
        if (out_ch.line_length !== head.len) begin
          $error("line_length: expected %0d, actual %0d", head.len, out_ch.line_length);
          fail_count++;
        end
      end
    end
    if (ready_hold != 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) ready_hold = pick_gap();
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int                    phase_no;
    int                    phase_target;
    logic                  m;
    logic [PATTERN_W-1:0]  pat;
    logic [PLEN_W-1:0]     pl;
    logic [TICKS_W-1:0]    tmo;
    logic [LFWAIT_W-1:0]   lfw;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_START;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_MATCH_MODE;
    cfg_wdata       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings first
    directed_steps.push_back(step_item(ACT_TICK, 8'h00, 1'b1));
    directed_steps.push_back(step_item(ACT_BYTE, 8'hFF, 1'b1));
    directed_steps.push_back(step_item(ACT_NONE, 8'h5A, 1'b1));
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, "O"));
    directed_steps.push_back(step_item(ACT_BYTE, "K"));
    directed_steps.push_back(step_item(ACT_BYTE, CH_LF, 1'b1, 1'b1, OUT_SUCCESS, 7'd2));
    // empty line is skipped, byte deciding after CR is dropped
    directed_steps.push_back(step_item(ACT_START, 8'hFF));
    directed_steps.push_back(step_item(ACT_BYTE, CH_LF, 1'b1));
    directed_steps.push_back(step_item(ACT_BYTE, "E"));
    directed_steps.push_back(step_item(ACT_BYTE, "R"));
    directed_steps.push_back(step_item(ACT_BYTE, "R"));
    directed_steps.push_back(step_item(ACT_BYTE, "O"));
    directed_steps.push_back(step_item(ACT_BYTE, "R"));
    directed_steps.push_back(step_item(ACT_BYTE, CH_CR));
    directed_steps.push_back(step_item(ACT_BYTE, "X", 1'b1, 1'b1, OUT_ERROR, 7'd5));
    // restart in the middle of a line
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, "O"));
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, "K"));
    directed_steps.push_back(step_item(ACT_BYTE, CH_LF, 1'b1));
    // zero budget times out on the first tick
    directed_steps.push_back(step_cfg(REG_TIMEOUT_MS, 64'd0));
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_TICK, 8'h00, 1'b1, 1'b1, OUT_TIMEOUT, 7'd0));
    // prefix mode, CR ended by a tick with no LF wait
    directed_steps.push_back(step_cfg(REG_TIMEOUT_MS, 64'd65535));
    directed_steps.push_back(step_cfg(REG_LF_WAIT_TICKS, 64'd0));
    directed_steps.push_back(step_cfg(REG_MATCH_MODE, 64'd1));
    directed_steps.push_back(step_cfg(REG_MATCH_PATTERN, 64'h0000_0000_5153_432B));
    directed_steps.push_back(step_cfg(REG_PATTERN_LENGTH, 64'd4));
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, "+"));
    directed_steps.push_back(step_item(ACT_BYTE, "C"));
    directed_steps.push_back(step_item(ACT_BYTE, "S"));
    directed_steps.push_back(step_item(ACT_BYTE, "Q"));
    directed_steps.push_back(step_item(ACT_BYTE, ":"));
    directed_steps.push_back(step_item(ACT_BYTE, CH_CR));
    directed_steps.push_back(step_item(ACT_TICK, 8'h00));
    // zero pattern length matches any line that is not empty
    directed_steps.push_back(step_cfg(REG_PATTERN_LENGTH, 64'd0));
    directed_steps.push_back(step_item(ACT_START, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, 8'h00));
    directed_steps.push_back(step_item(ACT_BYTE, CH_LF));

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_for_quiet();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
        cfg_we <= 1'b0;
      end else begin
        send_item(directed_steps[i].act, directed_steps[i].ch, directed_steps[i].typed,
                  directed_steps[i].hit, directed_steps[i].reply);
      end
    end

    // random phases, each under its own register setting
    live_items = 0;
    phase_no   = 0;
    while (live_items < RANDOM_ITEMS) begin
      case (phase_no)
        0: begin
          m = 1'b0; pat = '0; pl = 4'd1; tmo = 16'd1; lfw = 8'd0;
        end
        1: begin
          m = 1'b1; pat = '1; pl = 4'd8; tmo = 16'hFFFF; lfw = 8'hFF;
        end
        default: begin
          m = 1'($urandom_range(0, 1));
          for (int b = 0; b < 8; b++) begin
            pat[8*b +: 8] = ($urandom_range(0, 9) != 0) ?
                            BYTE_W'($urandom_range(8'h21, 8'h7E)) : BYTE_W'($urandom);
          end
          pl = ($urandom_range(0, 9) != 0) ? PLEN_W'($urandom_range(1, 8))
                                           : PLEN_W'($urandom_range(0, 15));
          case ($urandom_range(0, 9))
            0:       tmo = ($urandom_range(0, 2) == 0) ? 16'd0 : TICKS_W'($urandom);
            1, 2, 3: tmo = TICKS_W'($urandom_range(41, 400));
            default: tmo = TICKS_W'($urandom_range(3, 40));
          endcase
          case ($urandom_range(0, 9))
            0, 1, 2: lfw = LFWAIT_W'($urandom_range(0, 1));
            3:       lfw = 8'hFF;
            default: lfw = LFWAIT_W'($urandom_range(2, 20));
          endcase
        end
      endcase
      calm = (phase_no == 3);
      wait_for_quiet();
      write_reg(REG_MATCH_MODE, CFG_DATA_W'(m));
      write_reg(REG_MATCH_PATTERN, pat);
      write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(pl));
      write_reg(REG_TIMEOUT_MS, CFG_DATA_W'(tmo));
      write_reg(REG_LF_WAIT_TICKS, CFG_DATA_W'(lfw));
      cfg_we <= 1'b0;

      phase_target = live_items + PHASE_ITEMS;
      while (live_items < phase_target && live_items < RANDOM_ITEMS) begin
        send_reply_sequence();
        // now and then hold the sender until all replies are out
        if ($urandom_range(0, 29) == 0) wait_for_quiet();
      end
      phase_no++;
    end

    // drain and report
    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/atrlm_pkg.sv
rtl/core/atrlm_in_if.sv
rtl/core/atrlm_out_if.sv
rtl/core/at_response_line_matcher.sv
dv/testbench.sv
